// ----- hw/rtl/urlpn_pkg.sv -----
package urlpn_pkg;

  localparam int BUFFER_DEPTH_DEF = 256;

  localparam logic [8:0] LEN_MAX   = 9'd511;
  localparam logic [8:0] CAP_RESET = 9'd256;

  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_BAR    = 8'h7c;
  localparam logic [7:0] CH_DEL    = 8'h7f;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] path_byte;
    logic [7:0] read_index;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic       ok;
    logic [7:0] out_length;
    logic [7:0] out_byte;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_cmd_t;

  function automatic logic is_sep(input logic [7:0] b);
    return (b == CH_SLASH) || (b == CH_BSLASH);
  endfunction

  function automatic logic is_bad(input logic [7:0] b);
    return (b < CH_SPACE) || (b == CH_DEL) || (b == CH_COLON) || (b == CH_STAR) ||
           (b == CH_QMARK) || (b == CH_DQUOTE) || (b == CH_LT) || (b == CH_GT) ||
           (b == CH_BAR);
  endfunction

endpackage

// ----- hw/rtl/urlpn_seg_stack.sv -----
module urlpn_seg_stack #(
  parameter int BUFFER_DEPTH = urlpn_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  urlpn_pkg::stk_cmd_t                   cmd,
  input  logic [$clog2(BUFFER_DEPTH)-1:0]       push_value,
  output logic [$clog2(BUFFER_DEPTH)-1:0]       top,
  output logic [$clog2(BUFFER_DEPTH/2+1)-1:0]   count
);

  localparam int STACK_DEPTH = BUFFER_DEPTH / 2;
  localparam int VW          = $clog2(BUFFER_DEPTH);
  localparam int CW          = $clog2(STACK_DEPTH + 1);
  localparam int SAW         = $clog2(STACK_DEPTH);

  // top entry lives in top, the rest below it in mem
  logic [VW-1:0]  mem [STACK_DEPTH];
  logic [CW-1:0]  count_next;
  logic [SAW-1:0] wa;
  logic [SAW-1:0] ra;
  logic           we;
  logic [VW-1:0]  rd;
  logic [VW-1:0]  fwd_data;
  logic           fwd_hit;
  logic [VW-1:0]  below;

  always_comb begin
    priority if (cmd.clear) begin
      count_next = '0;
    end else if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
    we    = cmd.push && !cmd.clear && (count != '0);
    wa    = SAW'(count - CW'(1));
    ra    = SAW'(count_next - CW'(2));
    below = fwd_hit ? fwd_data : rd;
  end

  // entry under the next top is prefetched every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= top;
    end
    rd <= mem[ra];
  end

  always_ff @(posedge clk) begin
    fwd_data <= top;
    if (!cmd.clear) begin
      if (cmd.push) begin
        top <= push_value;
      end else if (cmd.pop) begin
        top <= below;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      fwd_hit <= 1'b0;
    end else begin
      count   <= count_next;
      fwd_hit <= we && (wa == ra);
    end
  end

endmodule

// ----- hw/rtl/url_path_normalizer.sv -----
// channel | dir | handshake            | beat
// req     | in  | req_valid/req_ready  | urlpn_pkg::req_t (opcode, path_byte, read_index)
// rsp     | out | rsp_valid/rsp_ready  | urlpn_pkg::rsp_t (kind, ok, out_length, out_byte)
// cfg     | in  | cfg_we               | cfg_wdata: capacity
//
// one request beat per cycle while req_ready is high; a result passes through the read stage,
// which holds the registered read of the path store, and then through the output register
// the segment-start stack keeps its top in a register and prefetches the entry below,
// so a two-dot pop is taken without stalling requests
// synchronous reset, no clearing pass: store contents are only used below the length
// req_ready drops only while both the read stage and the output register are full
module url_path_normalizer #(
  parameter int BUFFER_DEPTH = urlpn_pkg::BUFFER_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  urlpn_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output urlpn_pkg::rsp_t   rsp,
  input  logic              cfg_we,
  input  logic [8:0]        cfg_wdata
);

  localparam int STACK_DEPTH = BUFFER_DEPTH / 2;
  localparam int AW          = $clog2(BUFFER_DEPTH);
  localparam int CNTW        = $clog2(STACK_DEPTH + 1);
  localparam int SW          = $clog2(BUFFER_DEPTH + 513);

  logic [8:0]      capacity;
  logic [AW-1:0]   kept;
  logic [8:0]      cur;
  logic            dots;
  logic [7:0]      last;
  logic            failed;
  logic [AW-1:0]   shown;
  logic            path_done;

  logic [AW-1:0]   kept_next;
  logic [8:0]      cur_next;
  logic            dots_next;
  logic [7:0]      last_next;
  logic            failed_next;
  logic [AW-1:0]   shown_next;
  logic            path_done_next;

  logic [7:0]      store [BUFFER_DEPTH];
  logic [7:0]      store_rd;
  logic            store_we;
  logic [AW-1:0]   store_wa;
  logic [7:0]      store_wd;
  logic            store_re;

  urlpn_pkg::stk_cmd_t stk_cmd;
  logic [AW-1:0]   stk_top;
  logic [CNTW-1:0] stk_count;

  logic            accept;
  logic            start;
  logic [AW-1:0]   kept_c;
  logic [8:0]      cur_c;
  logic            dots_c;
  logic [7:0]      last_c;
  logic            failed_c;
  logic [CNTW-1:0] cnt_c;
  logic            slash;
  logic [SW-1:0]   cap_eff;
  logic [SW-1:0]   seg_end;
  logic            seg_act;
  logic            es_fail;
  logic            es_push;
  logic            es_pop;
  logic [AW-1:0]   es_kept;
  logic            good;

  logic            s1_valid;
  logic            s1_load;
  logic            s1_adv;
  logic            s1_kind;
  logic            s1_ok;
  logic [7:0]      s1_len;
  logic            s1_inrange;
  logic            s1_idx0;
  logic            s1_kind_next;
  logic            s1_ok_next;
  logic [7:0]      s1_len_next;
  logic            s1_inrange_next;

  assign s1_adv    = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || s1_adv;
  assign accept    = req_valid && req_ready;

  // a byte or finish after a finish starts a new path
  assign start    = path_done && ((req.opcode == urlpn_pkg::OP_BYTE) ||
                                  (req.opcode == urlpn_pkg::OP_FINISH));
  assign kept_c   = start ? AW'(1) : kept;
  assign cur_c    = start ? 9'd0 : cur;
  assign dots_c   = start ? 1'b1 : dots;
  assign last_c   = start ? 8'd0 : last;
  assign failed_c = start ? 1'b0 : failed;
  assign cnt_c    = start ? '0 : stk_count;

  assign slash   = kept_c > AW'(1);
  assign cap_eff = (SW'(capacity) < SW'(BUFFER_DEPTH)) ? SW'(capacity) : SW'(BUFFER_DEPTH);
  assign seg_end = SW'(kept_c) + SW'(slash) + SW'(cur_c);
  assign seg_act = (req.opcode == urlpn_pkg::OP_FINISH) ||
                   ((req.opcode == urlpn_pkg::OP_BYTE) && urlpn_pkg::is_sep(req.path_byte));

  // segment close
  always_comb begin
    es_fail = 1'b0;
    es_push = 1'b0;
    es_pop  = 1'b0;
    es_kept = kept_c;
    if ((cur_c != 9'd0) && !failed_c && !(dots_c && (cur_c == 9'd1))) begin
      priority if (dots_c && (cur_c == 9'd2)) begin
        if (cnt_c == '0) begin
          es_fail = 1'b1;
        end else begin
          es_pop  = 1'b1;
          es_kept = stk_top;
        end
      end else if ((last_c == urlpn_pkg::CH_DOT) || (last_c == urlpn_pkg::CH_SPACE)) begin
        es_fail = 1'b1;
      end else if ((SW'(kept_c) >= cap_eff) || (seg_end >= cap_eff)) begin
        es_fail = 1'b1;
      end else if (cnt_c >= CNTW'(STACK_DEPTH)) begin
        es_fail = 1'b1;
      end else begin
        es_push = 1'b1;
        es_kept = AW'(seg_end);
      end
    end
  end

  always_comb begin
    kept_next       = kept;
    cur_next        = cur;
    dots_next       = dots;
    last_next       = last;
    failed_next     = failed;
    shown_next      = shown;
    path_done_next  = path_done;
    store_we        = 1'b0;
    store_wa        = AW'(seg_end);
    store_wd        = req.path_byte;
    store_re        = 1'b0;
    stk_cmd         = '0;
    good            = 1'b0;
    s1_load         = 1'b0;
    s1_kind_next    = urlpn_pkg::KIND_STATUS;
    s1_ok_next      = 1'b0;
    s1_len_next     = 8'd0;
    s1_inrange_next = 1'b0;
    if (accept) begin
      if (start) begin
        stk_cmd.clear  = 1'b1;
        shown_next     = '0;
        path_done_next = 1'b0;
      end
      if (seg_act) begin
        kept_next   = es_kept;
        cur_next    = 9'd0;
        dots_next   = 1'b1;
        last_next   = last_c;
        failed_next = failed_c || es_fail;
        stk_cmd.push = es_push;
        stk_cmd.pop  = es_pop;
        // separator ahead of a kept segment goes in when the segment closes
        store_we    = es_push && slash;
        store_wa    = kept_c;
        store_wd    = urlpn_pkg::CH_SLASH;
      end
      unique case (req.opcode)
        urlpn_pkg::OP_BYTE: begin
          if (!urlpn_pkg::is_sep(req.path_byte)) begin
            kept_next   = kept_c;
            failed_next = failed_c || urlpn_pkg::is_bad(req.path_byte);
            dots_next   = dots_c && (req.path_byte == urlpn_pkg::CH_DOT);
            last_next   = req.path_byte;
            cur_next    = (cur_c == urlpn_pkg::LEN_MAX) ? cur_c : cur_c + 9'd1;
            store_we    = !failed_next && (seg_end < SW'(BUFFER_DEPTH));
          end
        end
        urlpn_pkg::OP_FINISH: begin
          good            = !failed_next && (cap_eff >= SW'(2));
          shown_next      = good ? kept_next : '0;
          path_done_next  = 1'b1;
          s1_load         = 1'b1;
          s1_kind_next    = urlpn_pkg::KIND_STATUS;
          s1_ok_next      = good;
          s1_len_next     = 8'(shown_next);
        end
        urlpn_pkg::OP_READ: begin
          store_re        = 1'b1;
          s1_load         = 1'b1;
          s1_kind_next    = urlpn_pkg::KIND_READ;
          s1_ok_next      = shown != '0;
          s1_len_next     = 8'(shown);
          s1_inrange_next = SW'(req.read_index) < SW'(shown);
        end
        default: begin
        end
      endcase
    end
  end

  // path store, entry 0 is the root slash and never written
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[store_wa] <= store_wd;
    end
    if (store_re) begin
      store_rd <= store[AW'(req.read_index)];
    end
  end

  urlpn_seg_stack #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_seg_stack (
    .clk        (clk),
    .rst        (rst),
    .cmd        (stk_cmd),
    .push_value (kept_c),
    .top        (stk_top),
    .count      (stk_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= urlpn_pkg::CAP_RESET;
      kept      <= AW'(1);
      cur       <= 9'd0;
      dots      <= 1'b1;
      last      <= 8'd0;
      failed    <= 1'b0;
      shown     <= '0;
      path_done <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      kept      <= kept_next;
      cur       <= cur_next;
      dots      <= dots_next;
      last      <= last_next;
      failed    <= failed_next;
      shown     <= shown_next;
      path_done <= path_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind    <= s1_kind_next;
      s1_ok      <= s1_ok_next;
      s1_len     <= s1_len_next;
      s1_inrange <= s1_inrange_next;
      s1_idx0    <= req.read_index == 8'd0;
    end
    if (s1_adv && s1_valid) begin
      rsp.kind       <= s1_kind;
      rsp.ok         <= s1_ok;
      rsp.out_length <= s1_len;
      rsp.out_byte   <= !s1_inrange ? 8'd0 : (s1_idx0 ? urlpn_pkg::CH_SLASH : store_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= s1_load;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stk_count <= CNTW'(STACK_DEPTH))
    else $error("segment stack over depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    stk_cmd.pop |-> (stk_count != '0) && !stk_cmd.clear)
    else $error("pop from empty segment stack");

  a_kept_nonzero: assert property (@(posedge clk) disable iff (rst)
    kept != '0)
    else $error("kept length lost the root");

  a_shown_done: assert property (@(posedge clk) disable iff (rst)
    (shown != '0) |-> path_done)
    else $error("readable length while a path is open");

endmodule
